### hdl/smsof_pkg.sv
// Shared types for the segment mean and sigma clipping filter.
// Holds the channel item structs, the controller/datapath command and status structs
// and the register index codes. No dependencies.
package smsof_pkg;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               end_of_set;
	} smp_t;

	typedef struct packed {
		logic signed [24:0] fluctuation;
		logic signed [23:0] segment_mean;
		logic signed [23:0] running_min;
		logic signed [23:0] running_max;
		logic               last_of_run;
		logic               status;
	} res_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic fin_start;
		logic fin_var;
		logic fin_rhs;
		logic fin_mean;
		logic em_d;
		logic em_sq;
		logic put_res;
		logic put_stat;
		logic idx_inc;
		logic clr_part;
		logic end_set;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic eos;
		logic seen;
		logic div_done;
		logic out_free;
		logic last_idx;
	} stat_t;

	localparam logic REG_SEG_LEN = 1'b0;
	localparam logic REG_SIGMA   = 1'b1;

	localparam logic [5:0] SEG_LEN_RESET = 6'd32;
	localparam logic [7:0] SIGMA_RESET   = 8'd32;

endpackage

### hdl/segment_mean_sigma_outlier_filter.sv
// Top level of the segment mean and sigma clipping filter.
// Holds the APB register file; instantiates smsof_ctrl and smsof_dp. Depends on smsof_pkg.
//
//  channel  | direction | handshake            | item
//  smp      | in        | smp_valid/smp_stall  | smp_t: sample, end_of_set
//  res      | out       | res_valid/res_stall  | res_t: fluctuation .. status
//  apb      | in        | psel/penable/pready  | segment_length, sigma_threshold
//
// A sample is first stored in the buffer, then added into the sums.
// A completed segment then runs the bit-serial divider for the mean, and each result
// passes through the buffer read port and the squaring multiplier.
// Reset needs no clearing pass.
// While a result waits in the output register the sequence holds; input items are
// stalled whenever the controller is not idle.
module segment_mean_sigma_outlier_filter import smsof_pkg::*; #(
	parameter int MAX_SEGMENT = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        smp_valid,
	output logic        smp_stall,
	input  smp_t        smp_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW = $clog2(MAX_SEGMENT + 1);

	logic [5:0]    len_q;
	logic [7:0]    sigma_q;
	logic [LW-1:0] eff_len;
	logic          wr_en;
	logic          len_wr;
	cmd_t          cmd;
	stat_t         stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign len_wr = wr_en && (paddr[2] == REG_SEG_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= SEG_LEN_RESET;
			sigma_q <= SIGMA_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SEG_LEN: len_q   <= pwdata[5:0];
				REG_SIGMA:   sigma_q <= pwdata[7:0];
				default:     len_q   <= len_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SEG_LEN: prdata = {26'd0, len_q};
			REG_SIGMA:   prdata = {24'd0, sigma_q};
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		if (len_q == 6'd0) eff_len = LW'(1);
		else if ({1'b0, len_q} > 7'(MAX_SEGMENT)) eff_len = LW'(MAX_SEGMENT);
		else eff_len = LW'(len_q);
	end

	smsof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.len_wr    (len_wr),
		.stat      (stat),
		.smp_stall (smp_stall),
		.cmd       (cmd)
	);

	smsof_dp #(
		.MAX_SEGMENT (MAX_SEGMENT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.smp_data  (smp_data),
		.seg_len   (eff_len),
		.sigma     (sigma_q),
		.res_stall (res_stall),
		.stat      (stat),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

endmodule

### hdl/smsof_ctrl.sv
// Controller state machine of the segment filter.
// Sequences sample intake, segment statistics, result emission and set end.
// Depends on smsof_pkg.
module smsof_ctrl import smsof_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  smp_valid,
	input  logic  len_wr,
	input  stat_t stat,
	output logic  smp_stall,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_FIN_START,
		S_FIN_VAR,
		S_FIN_RHS,
		S_FIN_DIV,
		S_EM_RD,
		S_EM_D,
		S_EM_SQ,
		S_EM_PUT,
		S_STAT_PUT
	} state_t;

	state_t state_q;

	assign smp_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept   = smp_valid;
				cmd.clr_part = len_wr;
			end
			S_ACC: begin
				cmd.acc     = 1'b1;
				cmd.end_set = !stat.full && stat.eos && stat.seen;
			end
			S_FIN_START: cmd.fin_start = 1'b1;
			S_FIN_VAR:   cmd.fin_var   = 1'b1;
			S_FIN_RHS:   cmd.fin_rhs   = 1'b1;
			S_FIN_DIV:   cmd.fin_mean  = stat.div_done;
			S_EM_RD:     cmd = '0;
			S_EM_D:      cmd.em_d      = 1'b1;
			S_EM_SQ:     cmd.em_sq     = 1'b1;
			S_EM_PUT: begin
				cmd.put_res = stat.out_free;
				if (stat.out_free) begin
					if (stat.last_idx) begin
						cmd.end_set  = stat.eos;
						cmd.clr_part = !stat.eos;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_STAT_PUT: begin
				cmd.put_stat = stat.out_free;
				cmd.end_set  = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (smp_valid) state_q <= S_ACC;
				end
				S_ACC: begin
					if (stat.full) state_q <= S_FIN_START;
					else if (stat.eos && !stat.seen) state_q <= S_STAT_PUT;
					else state_q <= S_IDLE;
				end
				S_FIN_START: state_q <= S_FIN_VAR;
				S_FIN_VAR:   state_q <= S_FIN_RHS;
				S_FIN_RHS:   state_q <= S_FIN_DIV;
				S_FIN_DIV: begin
					if (stat.div_done) state_q <= S_EM_RD;
				end
				S_EM_RD: state_q <= S_EM_D;
				S_EM_D:  state_q <= S_EM_SQ;
				S_EM_SQ: state_q <= S_EM_PUT;
				S_EM_PUT: begin
					if (stat.out_free) begin
						if (stat.last_idx) state_q <= S_IDLE;
						else state_q <= S_EM_RD;
					end
				end
				S_STAT_PUT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/smsof_dp.sv
// Datapath of the segment filter: sample buffer, sums, bit-serial divider,
// outlier test and output register. Driven by smsof_ctrl commands.
// Depends on smsof_pkg.
module smsof_dp import smsof_pkg::*; #(
	parameter int MAX_SEGMENT = 32,
	parameter int SAMPLE_BITS = 16,
	localparam int LW = $clog2(MAX_SEGMENT + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  smp_t          smp_data,
	input  logic [LW-1:0] seg_len,
	input  logic [7:0]    sigma,
	input  logic          res_stall,
	output stat_t         stat,
	output logic          res_valid,
	output res_t          res_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int AW   = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
	localparam int SW   = SB + LW;
	localparam int QW   = 2 * SB + LW;
	localparam int VW   = 2 * SW;
	localparam int DW   = SB + LW + 2;
	localparam int MNW  = SB + 9;
	localparam int RW   = SB + 10;
	localparam int NW   = SW + 8;
	localparam int CW   = VW + 16;
	localparam int XW   = SB + 26;
	localparam int CNTW = $clog2(NW + 1);

	logic signed [SB-1:0] mem_q [MAX_SEGMENT];
	logic signed [SB-1:0] rd_q;
	logic signed [SB-1:0] x_in;
	logic signed [SB-1:0] x_q;
	logic [2*SB-1:0]      sq_q;
	logic                 eos_q;
	logic [LW-1:0]        fill_q;
	logic [LW-1:0]        idx_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]        sumsq_q;
	logic [VW-1:0]        pa_q;
	logic [VW-1:0]        pb_q;
	logic [VW-1:0]        var_q;
	logic [15:0]          sig2_q;
	logic [CW-1:0]        rhs_q;
	logic                 neg_q;
	logic [NW-1:0]        dq_q;
	logic [LW-1:0]        rem_q;
	logic [CNTW-1:0]      cnt_q;
	logic signed [MNW-1:0] mean_q;
	logic signed [MNW-1:0] min_q;
	logic signed [MNW-1:0] max_q;
	logic                 seen_q;
	logic signed [DW-1:0] d_s1;
	logic signed [RW-1:0] res_s1;
	logic [2*DW-1:0]      sq2_s2;
	logic signed [RW-1:0] res_s2;
	logic                 res_valid_q;
	res_t                 res_q;

	logic [SW-1:0]        mag_c;
	logic [LW:0]          trial_c;
	logic [NW-1:0]        qa_c;
	logic [NW-1:0]        mfull_c;
	logic signed [MNW-1:0] mean_c;
	logic signed [DW-1:0] lv_c;
	logic signed [RW-1:0] res_c;
	logic [DW-1:0]        ad_c;
	logic [CW-1:0]        lhs_c;
	logic signed [XW-1:0] fl_c;
	logic signed [XW-1:0] mx_c;
	logic signed [XW-1:0] mn_c;
	logic signed [XW-1:0] mm_c;
	logic                 out_free;

	if (SB <= 16) begin : g_narrow
		assign x_in = smp_data.sample[SB-1:0];
	end else begin : g_wide
		assign x_in = {{(SB - 16){1'b0}}, smp_data.sample};
	end

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		mag_c   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
		trial_c = {rem_q, dq_q[NW-1]};
		qa_c    = dq_q + NW'(neg_q && (rem_q != '0));
		mfull_c = neg_q ? -qa_c : qa_c;
		mean_c  = mfull_c[MNW-1:0];
		lv_c    = DW'($signed({1'b0, seg_len})) * DW'($signed(rd_q));
		res_c   = RW'($signed({rd_q, 8'h00})) - RW'(mean_q);
		ad_c    = d_s1[DW-1] ? DW'(-d_s1) : DW'(d_s1);
		lhs_c   = CW'({sq2_s2, 8'h00});
		fl_c    = (lhs_c > rhs_q) ? XW'(mean_q) : XW'(res_s2);
		mm_c    = XW'(mean_q);
		mn_c    = XW'(min_q);
		mx_c    = XW'(max_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) mem_q[fill_q[AW-1:0]] <= x_in;
		rd_q <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= x_in;
			sq_q  <= (2*SB)'(x_in * x_in);
		end
		if (cmd.fin_start) begin
			pa_q   <= VW'(seg_len) * VW'(sumsq_q);
			pb_q   <= VW'(VW'(sum_q) * VW'(sum_q));
			sig2_q <= 16'(sigma) * 16'(sigma);
		end
		if (cmd.fin_var) var_q <= pa_q - pb_q;
		if (cmd.fin_rhs) rhs_q <= CW'(sig2_q) * CW'(var_q);
		if (cmd.fin_mean) mean_q <= mean_c;
		if (cmd.em_d) begin
			d_s1   <= lv_c - DW'(sum_q);
			res_s1 <= res_c;
		end
		if (cmd.em_sq) begin
			sq2_s2 <= {{DW{1'b0}}, ad_c} * {{DW{1'b0}}, ad_c};
			res_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eos_q   <= 1'b0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			idx_q   <= '0;
			seen_q  <= 1'b0;
			min_q   <= '0;
			max_q   <= '0;
			neg_q   <= 1'b0;
			dq_q    <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.accept) eos_q <= smp_data.end_of_set;
			if (cmd.end_set || cmd.clr_part) begin
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end else if (cmd.accept) begin
				fill_q <= fill_q + LW'(1);
			end else if (cmd.acc) begin
				sum_q   <= sum_q + SW'(x_q);
				sumsq_q <= sumsq_q + QW'(sq_q);
			end
			if (cmd.fin_start) begin
				neg_q <= sum_q[SW-1];
				dq_q  <= {mag_c, 8'h00};
				rem_q <= '0;
				cnt_q <= CNTW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (trial_c >= {1'b0, seg_len}) begin
					rem_q <= LW'(trial_c - {1'b0, seg_len});
					dq_q  <= {dq_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial_c[LW-1:0];
					dq_q  <= {dq_q[NW-2:0], 1'b0};
				end
			end
			if (cmd.end_set) begin
				seen_q <= 1'b0;
				min_q  <= '0;
				max_q  <= '0;
			end else if (cmd.fin_mean) begin
				seen_q <= 1'b1;
				if (!seen_q || mean_c < min_q) min_q <= mean_c;
				if (!seen_q || mean_c > max_q) max_q <= mean_c;
			end
			if (cmd.fin_mean) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.put_res || cmd.put_stat) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_res) begin
			res_q.fluctuation  <= fl_c[24:0];
			res_q.segment_mean <= mm_c[23:0];
			res_q.running_min  <= mn_c[23:0];
			res_q.running_max  <= mx_c[23:0];
			res_q.last_of_run  <= stat.last_idx;
			res_q.status       <= 1'b0;
		end else if (cmd.put_stat) begin
			res_q.fluctuation  <= '0;
			res_q.segment_mean <= '0;
			res_q.running_min  <= '0;
			res_q.running_max  <= '0;
			res_q.last_of_run  <= 1'b1;
			res_q.status       <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign stat.full     = (fill_q == seg_len);
	assign stat.eos      = eos_q;
	assign stat.seen     = seen_q;
	assign stat.div_done = (cnt_q == '0);
	assign stat.out_free = out_free;
	assign stat.last_idx = (LW'(idx_q + LW'(1)) == seg_len);

	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_res || cmd.put_stat) |-> out_free)
		else $error("Result loaded while output register is occupied.");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= seg_len)
		else $error("Fill count exceeds segment length.");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_mean |-> cnt_q == '0)
		else $error("Mean taken before division finished.");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.em_d |-> idx_q < seg_len)
		else $error("Emission index beyond segment.");

endmodule
